FILE: sv/epq_pkg.sv
package epq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 24;
   localparam int LEVEL_W             = 5;
   localparam int CODE_W              = 16;
   localparam int PARAM_W             = 32;
   localparam int STAMP_W             = 32;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_FLUSH   = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [CODE_W-1:0]         code;
      logic signed [PARAM_W-1:0] param;
      logic [STAMP_W-1:0]        timestamp;
   } event_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } chain_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } chain_status_type;

endpackage

FILE: sv/epq_cell.sv
module epq_cell
   import epq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  event_type     new_event,
   input  event_type     next_event,
   output event_type     data
);

   event_type data_ff;
   event_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = new_event;
      end else if (ctrl.shift) begin
         data_in = next_event;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: sv/epq_chain.sv
module epq_chain
   import epq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   localparam int CW         = $clog2(QUEUE_DEPTH + 1)
)(
   input  logic             clock,
   input  logic             reset,
   input  chain_ctrl_type   ctrl,
   input  event_type        new_event,
   output event_type        head,
   output logic [CW-1:0]    count,
   output chain_status_type status
);

   // Cell zero always holds the oldest entry; a pop moves every entry one cell
   // toward the head, and a push lands in the first unused cell.
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             full;
   logic             empty;
   event_type        cell_data [QUEUE_DEPTH];
   event_type        next_data [QUEUE_DEPTH];

   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type cell_ctrl;

      if (i < QUEUE_DEPTH - 1) begin : g_inner
         assign next_data[i] = cell_data[i+1];
      end else begin : g_last
         assign next_data[i] = new_event;
      end

      assign cell_ctrl.load  = ctrl.push && !full && (count_ff == CW'(i));
      assign cell_ctrl.shift = ctrl.pop && !empty;

      epq_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .new_event  (new_event),
         .next_event (next_data[i]),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.flush) begin
         count_in = '0;
      end else if (ctrl.push && !full) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop && !empty) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head         = cell_data[0];
   assign count        = count_ff;
   assign status.full  = full;
   assign status.empty = empty;

endmodule

FILE: sv/two_priority_event_queue.sv
// Strict-priority event queue with a high and a low FIFO of QUEUE_DEPTH events.
// A command is transferred at a rising edge where start is high and busy is
// low. busy stays low, so a new command can be given in every cycle.
// Opcodes: enqueue into the FIFO chosen by req_high_priority, dequeue the
// oldest high event (or the oldest low event when the high FIFO is empty),
// clear the sticky overflow flag, or flush both FIFOs and the flag.
// Each command yields exactly one response, shown for one cycle with rsp_valid
// high in the cycle right after the command; the throughput is one command per
// cycle. Each FIFO is a row of cells that shifts toward its head on a dequeue,
// so one cell update per command sets the rate.
// The response carries ok, the dequeued event (zero otherwise), the overflow
// flag and both fill levels after the command.
// The receiver cannot stall: a response not taken in its cycle is gone.
// A synchronous reset empties both FIFOs, clears the flag and drops rsp_valid;
// the stored events themselves are not cleared.
module two_priority_event_queue
   import epq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_opcode,
   input  logic [CODE_W-1:0]         req_event_code,
   input  logic signed [PARAM_W-1:0] req_event_param,
   input  logic [STAMP_W-1:0]        req_event_time,
   input  logic                      req_high_priority,
   output logic                      rsp_valid,
   output logic                      rsp_ok,
   output logic [CODE_W-1:0]         rsp_out_code,
   output logic signed [PARAM_W-1:0] rsp_out_param,
   output logic [STAMP_W-1:0]        rsp_out_time,
   output logic                      rsp_overflowed,
   output logic [LEVEL_W-1:0]        rsp_high_level,
   output logic [LEVEL_W-1:0]        rsp_low_level
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   opcode_type       opcode;
   logic             accept;
   event_type        new_event;
   event_type        high_head;
   event_type        low_head;
   logic [CW-1:0]    high_count;
   logic [CW-1:0]    low_count;
   chain_status_type high_status;
   chain_status_type low_status;
   chain_ctrl_type   high_ctrl;
   chain_ctrl_type   low_ctrl;

   logic             rsp_valid_ff;
   logic             rsp_ok_ff;
   logic             rsp_ok_in;
   event_type        rsp_event_ff;
   event_type        rsp_event_in;
   logic             overflow_ff;
   logic             overflow_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign opcode = opcode_type'(req_opcode);

   assign new_event.code      = req_event_code;
   assign new_event.param     = req_event_param;
   assign new_event.timestamp = req_event_time;

   always_comb begin
      high_ctrl    = '0;
      low_ctrl     = '0;
      rsp_ok_in    = 1'b0;
      rsp_event_in = '0;
      overflow_in  = overflow_ff;
      if (accept) begin
         case (opcode)
            OP_ENQUEUE: begin
               if (req_high_priority) begin
                  high_ctrl.push = 1'b1;
                  rsp_ok_in      = !high_status.full;
               end else begin
                  low_ctrl.push = 1'b1;
                  rsp_ok_in     = !low_status.full;
               end
               if (!rsp_ok_in) begin
                  overflow_in = 1'b1;
               end
            end
            OP_DEQUEUE: begin
               if (!high_status.empty) begin
                  high_ctrl.pop = 1'b1;
                  rsp_ok_in     = 1'b1;
                  rsp_event_in  = high_head;
               end else if (!low_status.empty) begin
                  low_ctrl.pop = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_event_in = low_head;
               end
            end
            OP_CLEAR: begin
               overflow_in = 1'b0;
            end
            OP_FLUSH: begin
               high_ctrl.flush = 1'b1;
               low_ctrl.flush  = 1'b1;
               overflow_in     = 1'b0;
            end
            default: begin
               overflow_in = overflow_ff;
            end
         endcase
      end
   end

   epq_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_high (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (high_ctrl),
      .new_event (new_event),
      .head      (high_head),
      .count     (high_count),
      .status    (high_status)
   );

   epq_chain #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_low (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (low_ctrl),
      .new_event (new_event),
      .head      (low_head),
      .count     (low_count),
      .status    (low_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         overflow_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         overflow_ff  <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_event_ff <= rsp_event_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_out_code   = rsp_event_ff.code;
   assign rsp_out_param  = rsp_event_ff.param;
   assign rsp_out_time   = rsp_event_ff.timestamp;
   assign rsp_overflowed = overflow_ff;
   assign rsp_high_level = LEVEL_W'(high_count);
   assign rsp_low_level  = LEVEL_W'(low_count);

   a_one_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == $past(accept && !reset))
      else $error("response strobe does not follow the command transfer");

   a_refused_sets_flag: assert property (@(posedge clock) disable iff (reset)
      accept && opcode == OP_ENQUEUE |=> rsp_ok_ff || overflow_ff)
      else $error("refused enqueue did not set the overflow flag");

   a_levels_bounded: assert property (@(posedge clock) disable iff (reset)
      high_count <= CW'(QUEUE_DEPTH) && low_count <= CW'(QUEUE_DEPTH))
      else $error("fill level beyond queue depth");

   a_low_waits_for_high: assert property (@(posedge clock) disable iff (reset)
      low_ctrl.pop |-> high_status.empty && !high_ctrl.pop)
      else $error("low queue served while high queue holds events");

endmodule

FILE: tb/sv/tb.sv
module tb;
   import epq_pkg::*;

   localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic                      ok;
      logic [CODE_W-1:0]         code;
      logic signed [PARAM_W-1:0] param;
      logic [STAMP_W-1:0]        stamp;
      logic                      overflowed;
      logic [LEVEL_W-1:0]        high_level;
      logic [LEVEL_W-1:0]        low_level;
   } response_type;

   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      start             = 1'b0;
   logic                      busy;
   logic [1:0]                req_opcode        = OP_DEQUEUE;
   logic [CODE_W-1:0]         req_event_code    = '0;
   logic signed [PARAM_W-1:0] req_event_param   = '0;
   logic [STAMP_W-1:0]        req_event_time    = '0;
   logic                      req_high_priority = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ok;
   logic [CODE_W-1:0]         rsp_out_code;
   logic signed [PARAM_W-1:0] rsp_out_param;
   logic [STAMP_W-1:0]        rsp_out_time;
   logic                      rsp_overflowed;
   logic [LEVEL_W-1:0]        rsp_high_level;
   logic [LEVEL_W-1:0]        rsp_low_level;

   event_type    high_events[$];
   event_type    low_events[$];
   logic         overflow_sticky = 1'b0;
   response_type awaited_responses[$];
   int           error_count     = 0;
   int           cycle_count     = 0;
   bit           idling_enabled  = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   two_priority_event_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_event_code   (req_event_code),
      .req_event_param  (req_event_param),
      .req_event_time   (req_event_time),
      .req_high_priority(req_high_priority),
      .rsp_valid        (rsp_valid),
      .rsp_ok           (rsp_ok),
      .rsp_out_code     (rsp_out_code),
      .rsp_out_param    (rsp_out_param),
      .rsp_out_time     (rsp_out_time),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_high_level   (rsp_high_level),
      .rsp_low_level    (rsp_low_level)
   );

   function automatic response_type apply_command(opcode_type op, event_type evt, logic hp);
      response_type resp;
      event_type    head;
      resp = '0;
      head = '0;
      case (op)
         OP_ENQUEUE: begin
            if (hp && high_events.size() < QUEUE_DEPTH) begin
               high_events.push_back(evt);
               resp.ok = 1'b1;
            end else if (!hp && low_events.size() < QUEUE_DEPTH) begin
               low_events.push_back(evt);
               resp.ok = 1'b1;
            end else begin
               overflow_sticky = 1'b1;
            end
         end
         OP_DEQUEUE: begin
            if (high_events.size() != 0) begin
               head = high_events.pop_front();
               resp.ok = 1'b1;
            end else if (low_events.size() != 0) begin
               head = low_events.pop_front();
               resp.ok = 1'b1;
            end
            resp.code  = head.code;
            resp.param = head.param;
            resp.stamp = head.timestamp;
         end
         OP_CLEAR: begin
            overflow_sticky = 1'b0;
         end
         default: begin
            high_events.delete();
            low_events.delete();
            overflow_sticky = 1'b0;
         end
      endcase
      resp.overflowed = overflow_sticky;
      resp.high_level = LEVEL_W'(high_events.size());
      resp.low_level  = LEVEL_W'(low_events.size());
      return resp;
   endfunction

   function automatic void check_field(string name, logic [31:0] wanted, logic [31:0] seen);
      if (seen !== wanted) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, wanted, seen);
         error_count++;
      end
   endfunction

   // The response check runs before the prediction so that the oldest entry is compared.
   always @(posedge clock) begin
      response_type wanted;
      event_type    evt;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (awaited_responses.size() == 0) begin
               $display("%0t: response with none expected, expected none, actual ok=%0b code=%0h",
                        $time, rsp_ok, rsp_out_code);
               error_count++;
            end else begin
               wanted = awaited_responses.pop_front();
               check_field("ok", 32'(wanted.ok), 32'(rsp_ok));
               check_field("out_code", 32'(wanted.code), 32'(rsp_out_code));
               check_field("out_param", wanted.param, rsp_out_param);
               check_field("out_time", wanted.stamp, rsp_out_time);
               check_field("overflowed", 32'(wanted.overflowed), 32'(rsp_overflowed));
               check_field("high_level", 32'(wanted.high_level), 32'(rsp_high_level));
               check_field("low_level", 32'(wanted.low_level), 32'(rsp_low_level));
            end
         end
         if (start && busy === 1'b0) begin
            evt.code      = req_event_code;
            evt.param     = req_event_param;
            evt.timestamp = req_event_time;
            awaited_responses.push_back(apply_command(opcode_type'(req_opcode), evt,
                                                      req_high_priority));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("two_priority_event_queue verification failed");
         $finish;
      end
   end

   task automatic send_cmd(opcode_type op, logic [CODE_W-1:0] code,
                           logic signed [PARAM_W-1:0] param, logic [STAMP_W-1:0] stamp,
                           logic hp);
      start             <= 1'b1;
      req_opcode        <= op;
      req_event_code    <= code;
      req_event_param   <= param;
      req_event_time    <= stamp;
      req_high_priority <= hp;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Idle bursts carry junk on the request fields, which must be ignored.
   task automatic maybe_idle();
      if (idling_enabled && $urandom_range(0, 7) == 0) begin
         start             <= 1'b0;
         req_opcode        <= 2'($urandom);
         req_event_code    <= CODE_W'($urandom);
         req_event_param   <= $urandom;
         req_event_time    <= $urandom;
         req_high_priority <= 1'($urandom);
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic send_random(int enq_pct, int deq_pct, int clr_pct);
      int         pick;
      opcode_type op;
      pick = $urandom_range(0, 99);
      if (pick < enq_pct) op = OP_ENQUEUE;
      else if (pick < enq_pct + deq_pct) op = OP_DEQUEUE;
      else if (pick < enq_pct + deq_pct + clr_pct) op = OP_CLEAR;
      else op = OP_FLUSH;
      maybe_idle();
      send_cmd(op, CODE_W'($urandom), $urandom, $urandom, 1'($urandom));
   endtask

   task automatic test_directed();
      send_cmd(OP_DEQUEUE, 16'h0000, 32'sd0, 32'h0000_0000, 1'b1);
      send_cmd(OP_ENQUEUE, 16'h0000, 32'sh8000_0000, 32'h0000_0000, 1'b0);
      maybe_idle();
      send_cmd(OP_ENQUEUE, 16'hFFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_cmd(OP_ENQUEUE, 16'h1234, -32'sd1, 32'h0000_0001, 1'b1);
      send_cmd(OP_ENQUEUE, 16'hFFFF, 32'sd0, 32'h8000_0000, 1'b1);
      send_cmd(OP_DEQUEUE, 16'hFFFF, -32'sd1, 32'hFFFF_FFFF, 1'b0);
      maybe_idle();
      send_cmd(OP_DEQUEUE, 16'h0000, 32'sd0, 32'h0000_0000, 1'b0);
      send_cmd(OP_DEQUEUE, 16'h0000, 32'sd0, 32'h0000_0000, 1'b1);
      send_cmd(OP_ENQUEUE, 16'h0005, 32'sd5, 32'h0000_0005, 1'b1);
      send_cmd(OP_DEQUEUE, 16'h0000, 32'sd0, 32'h0000_0000, 1'b0);
      send_cmd(OP_DEQUEUE, 16'h0000, 32'sd0, 32'h0000_0000, 1'b0);
      send_cmd(OP_DEQUEUE, 16'h0000, 32'sd0, 32'h0000_0000, 1'b0);
      send_cmd(OP_CLEAR, 16'hFFFF, -32'sd1, 32'hFFFF_FFFF, 1'b1);
      send_cmd(OP_ENQUEUE, 16'hA5A5, 32'sh5A5A_5A5A, 32'h0F0F_0F0F, 1'b0);
      send_cmd(OP_ENQUEUE, 16'h5A5A, 32'shA5A5_A5A5, 32'hF0F0_F0F0, 1'b1);
      maybe_idle();
      send_cmd(OP_FLUSH, 16'hFFFF, -32'sd1, 32'hFFFF_FFFF, 1'b1);
      send_cmd(OP_DEQUEUE, 16'h0000, 32'sd0, 32'h0000_0000, 1'b0);
      send_cmd(OP_ENQUEUE, 16'h0042, 32'sd42, 32'h0000_0042, 1'b0);
      send_cmd(OP_DEQUEUE, 16'h0000, 32'sd0, 32'h0000_0000, 1'b1);
   endtask

   // Enqueue bursts, most aimed at one queue, can drive it into overflow; the drain
   // bursts can then run past empty.
   task automatic test_fill_and_drain();
      int   bias;
      logic hp;
      repeat (12) begin
         bias = $urandom_range(0, 2);
         repeat ($urandom_range(20, 32)) begin
            hp = (bias == 2) ? 1'($urandom) : bias[0];
            maybe_idle();
            send_cmd(OP_ENQUEUE, CODE_W'($urandom), $urandom, $urandom, hp);
         end
         if ($urandom_range(0, 1) == 1) begin
            send_cmd(OP_CLEAR, CODE_W'($urandom), $urandom, $urandom, 1'($urandom));
         end
         repeat ($urandom_range(30, 56)) begin
            maybe_idle();
            send_cmd(OP_DEQUEUE, CODE_W'($urandom), $urandom, $urandom, 1'($urandom));
         end
      end
   endtask

   task automatic test_random_mix();
      repeat (750) send_random(45, 43, 8);
   endtask

   task automatic test_back_to_back();
      idling_enabled = 1'b0;
      repeat (350) send_random(52, 42, 4);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_drain();
      test_random_mix();
      test_back_to_back();
      start <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("two_priority_event_queue verification clean");
      end else begin
         $display("two_priority_event_queue verification failed");
      end
      $finish;
   end

endmodule
